// ===== sv/sdf_blend_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the distance blend unit checker.
// ----------------------------------------------------------------------------
`ifndef SDF_BLEND_UNIT_ASSERT_SVH
`define SDF_BLEND_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge outside of reset.
`define SBU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold at every rising clock edge outside of reset.
`define SBU_ASSERT_ALWAYS(label, cond, msg) \
    `SBU_ASSERT_IMP(label, 1'b1, cond, msg)

`endif

// ===== sv/sbu_pkg.sv =====
// ----------------------------------------------------------------------------
// sbu_pkg
// Shared widths, command codes and the pipeline carry record of the blend unit.
// ----------------------------------------------------------------------------
package sbu_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int K_WIDTH      = VALUE_WIDTH - 1;
    localparam int DIV_STEPS    = FRAC_BITS;
    localparam int WIDE_WIDTH   = VALUE_WIDTH + 4;
    // Input stage, driver stage, clamp stage, divider, three multiply/add stages, output.
    localparam int PIPE_LATENCY = DIV_STEPS + 7;

    typedef enum logic [1:0] {
        CMD_SMOOTH_UNION = 2'd0,
        CMD_SMOOTH_SUB   = 2'd1,
        CMD_HARD_MIN     = 2'd2,
        CMD_HARD_MAX     = 2'd3
    } cmd_t;

    // Everything an item needs after the clamp stage.
    typedef struct packed {
        logic                          union_op;
        logic                          bypass;
        logic signed [WIDE_WIDTH-1:0]  preset;
        logic signed [VALUE_WIDTH-1:0] base;
        logic signed [VALUE_WIDTH-1:0] drv;
        logic [K_WIDTH-1:0]            radius;
    } carry_t;

endpackage

// ===== sv/sdf_blend_unit.sv =====
// ----------------------------------------------------------------------------
// sdf_blend_unit
// Smooth and hard combination of two signed Q16.16 distance values.
//
// A beat is accepted at a rising edge where start is high and busy is low.
// busy is held low: the unit is a fully pipelined datapath and takes a new
// beat in every cycle. Each beat carries command, dist_a, dist_b and
// blend_width. Its result appears on blended and overflow, marked by done,
// for exactly one cycle; results leave in the order the beats came in. The
// path runs through three front stages, the 16-stage restoring divider (one
// quotient bit per stage) that forms the blend weight, and three multiply/add
// stages before the output register. Reset clears all stage valid bits, so
// nothing in flight survives it and done stays low until a new beat has
// passed through. The receiver cannot hold results off, so no stage ever
// stalls.
// ----------------------------------------------------------------------------
module sdf_blend_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            command,
    input  logic signed [sbu_pkg::VALUE_WIDTH-1:0] dist_a,
    input  logic signed [sbu_pkg::VALUE_WIDTH-1:0] dist_b,
    input  logic [sbu_pkg::K_WIDTH-1:0]           blend_width,
    output logic                                  done,
    output logic signed [sbu_pkg::VALUE_WIDTH-1:0] blended,
    output logic                                  overflow
);

    // ------------------------------------------------------------------
    // Stage 1: capture the beat and form the target t, which is a for
    // union and hard min, and -a for subtraction and hard max. t needs one
    // extra bit since the negated most negative a does not fit.
    // ------------------------------------------------------------------
    logic                                    s1_vld_reg, s1_vld_next;
    sbu_pkg::cmd_t                           s1_cmd_reg, s1_cmd_next;
    logic signed [sbu_pkg::VALUE_WIDTH:0]    s1_t_reg, s1_t_next;
    logic signed [sbu_pkg::VALUE_WIDTH-1:0]  s1_b_reg, s1_b_next;
    logic [sbu_pkg::K_WIDTH-1:0]             s1_k_reg, s1_k_next;
    logic signed [sbu_pkg::VALUE_WIDTH:0]    s1_a_ext;
    logic                                    s1_negate;

    always_comb
    begin
        s1_a_ext    = {dist_a[sbu_pkg::VALUE_WIDTH-1], dist_a};
        s1_negate   = (command == sbu_pkg::CMD_SMOOTH_SUB) ||
                      (command == sbu_pkg::CMD_HARD_MAX);
        s1_vld_next = start && !busy;
        s1_cmd_next = sbu_pkg::cmd_t'(command);
        s1_t_next   = s1_negate ? -s1_a_ext : s1_a_ext;
        s1_b_next   = dist_b;
        s1_k_next   = blend_width;
    end

    // ------------------------------------------------------------------
    // Stage 2: the blend driver d, which is b - a for union and -a - b for
    // subtraction. Both are b - t or t - b.
    // ------------------------------------------------------------------
    logic                                    s2_vld_reg, s2_vld_next;
    sbu_pkg::cmd_t                           s2_cmd_reg, s2_cmd_next;
    logic signed [sbu_pkg::VALUE_WIDTH:0]    s2_t_reg, s2_t_next;
    logic signed [sbu_pkg::VALUE_WIDTH-1:0]  s2_b_reg, s2_b_next;
    logic [sbu_pkg::K_WIDTH-1:0]             s2_k_reg, s2_k_next;
    logic signed [sbu_pkg::VALUE_WIDTH+1:0]  s2_d_reg, s2_d_next;
    logic signed [sbu_pkg::VALUE_WIDTH+1:0]  s2_t_ext;
    logic signed [sbu_pkg::VALUE_WIDTH+1:0]  s2_b_ext;

    always_comb
    begin
        s2_t_ext    = {s1_t_reg[sbu_pkg::VALUE_WIDTH], s1_t_reg};
        s2_b_ext    = {{2{s1_b_reg[sbu_pkg::VALUE_WIDTH-1]}}, s1_b_reg};
        s2_vld_next = s1_vld_reg;
        s2_cmd_next = s1_cmd_reg;
        s2_t_next   = s1_t_reg;
        s2_b_next   = s1_b_reg;
        s2_k_next   = s1_k_reg;
        s2_d_next   = (s1_cmd_reg == sbu_pkg::CMD_SMOOTH_UNION) ? (s2_b_ext - s2_t_ext)
                                                                : (s2_t_ext - s2_b_ext);
    end

    // ------------------------------------------------------------------
    // Stage 3: decide whether the result is already known. Hard commands
    // pick t or b by compare. A smooth command gives t when d >= k (this
    // also covers k = 0 with a tie) and b when d <= -k. Only the open band
    // -k < d < k needs the weight h = ((d + k) << 15) / k, whose dividend
    // d + k then lies strictly between 0 and 2k and fits the value width.
    // ------------------------------------------------------------------
    logic                                    s3_vld_reg, s3_vld_next;
    sbu_pkg::carry_t                         s3_carry_reg, s3_carry_next;
    logic [sbu_pkg::VALUE_WIDTH-1:0]         s3_num_reg, s3_num_next;
    logic signed [sbu_pkg::VALUE_WIDTH+1:0]  s3_k_ext;
    logic signed [sbu_pkg::VALUE_WIDTH+1:0]  s3_sum;
    logic                                    s3_at_t;
    logic                                    s3_at_b;
    logic                                    s3_hard;
    logic                                    s3_pick_t;
    logic signed [sbu_pkg::WIDE_WIDTH-1:0]   s3_t_wide;
    logic signed [sbu_pkg::WIDE_WIDTH-1:0]   s3_b_wide;

    always_comb
    begin
        s3_k_ext  = {3'b000, s2_k_reg};
        s3_sum    = s2_d_reg + s3_k_ext;
        s3_at_t   = s2_d_reg >= s3_k_ext;
        s3_at_b   = s3_sum[sbu_pkg::VALUE_WIDTH+1] || (s3_sum == '0);
        s3_hard   = (s2_cmd_reg == sbu_pkg::CMD_HARD_MIN) ||
                    (s2_cmd_reg == sbu_pkg::CMD_HARD_MAX);
        s3_t_wide = {{(sbu_pkg::WIDE_WIDTH-sbu_pkg::VALUE_WIDTH-1)
                      {s2_t_reg[sbu_pkg::VALUE_WIDTH]}}, s2_t_reg};
        s3_b_wide = {{(sbu_pkg::WIDE_WIDTH-sbu_pkg::VALUE_WIDTH)
                      {s2_b_reg[sbu_pkg::VALUE_WIDTH-1]}}, s2_b_reg};

        case (s2_cmd_reg)
            sbu_pkg::CMD_HARD_MIN: s3_pick_t = s2_t_reg <= s2_b_reg;
            sbu_pkg::CMD_HARD_MAX: s3_pick_t = s2_t_reg >= s2_b_reg;
            default:               s3_pick_t = s3_at_t;
        endcase

        s3_vld_next            = s2_vld_reg;
        s3_num_next            = s3_sum[sbu_pkg::VALUE_WIDTH-1:0];
        s3_carry_next.union_op = (s2_cmd_reg == sbu_pkg::CMD_SMOOTH_UNION);
        s3_carry_next.bypass   = s3_hard || s3_at_t || s3_at_b;
        s3_carry_next.preset   = s3_pick_t ? s3_t_wide : s3_b_wide;
        s3_carry_next.base     = s2_b_reg;
        s3_carry_next.drv      = s2_d_reg[sbu_pkg::VALUE_WIDTH-1:0];
        s3_carry_next.radius   = s2_k_reg;
    end

    // ------------------------------------------------------------------
    // Divider: one restoring step per stage. The first partial remainder
    // is (d + k) >> 1 with bit 0 of d + k shifted in, which is just d + k;
    // later steps shift in zeros. The remainder always stays below k.
    // ------------------------------------------------------------------
    logic                          div_vld_reg   [sbu_pkg::DIV_STEPS];
    logic                          div_vld_next  [sbu_pkg::DIV_STEPS];
    sbu_pkg::carry_t               div_carry_reg [sbu_pkg::DIV_STEPS];
    sbu_pkg::carry_t               div_carry_next[sbu_pkg::DIV_STEPS];
    logic [sbu_pkg::K_WIDTH-1:0]   div_rem_reg   [sbu_pkg::DIV_STEPS];
    logic [sbu_pkg::K_WIDTH-1:0]   div_rem_next  [sbu_pkg::DIV_STEPS];
    logic [sbu_pkg::FRAC_BITS-1:0] div_quo_reg   [sbu_pkg::DIV_STEPS];
    logic [sbu_pkg::FRAC_BITS-1:0] div_quo_next  [sbu_pkg::DIV_STEPS];
    logic [sbu_pkg::K_WIDTH:0]     div_trial     [sbu_pkg::DIV_STEPS];
    logic [sbu_pkg::K_WIDTH:0]     div_diff      [sbu_pkg::DIV_STEPS];
    logic [sbu_pkg::FRAC_BITS-1:0] div_qin       [sbu_pkg::DIV_STEPS];
    logic                          div_take      [sbu_pkg::DIV_STEPS];

    always_comb
    begin
        for (int i = 0; i < sbu_pkg::DIV_STEPS; i++)
        begin
            if (i == 0)
            begin
                div_vld_next[i]   = s3_vld_reg;
                div_carry_next[i] = s3_carry_reg;
                div_trial[i]      = s3_num_reg;
                div_qin[i]        = '0;
            end
            else
            begin
                div_vld_next[i]   = div_vld_reg[i-1];
                div_carry_next[i] = div_carry_reg[i-1];
                div_trial[i]      = {div_rem_reg[i-1], 1'b0};
                div_qin[i]        = div_quo_reg[i-1];
            end
            div_diff[i]     = div_trial[i] - {1'b0, div_carry_next[i].radius};
            div_take[i]     = div_trial[i] >= {1'b0, div_carry_next[i].radius};
            div_rem_next[i] = div_take[i] ? div_diff[i][sbu_pkg::K_WIDTH-1:0]
                                          : div_trial[i][sbu_pkg::K_WIDTH-1:0];
            div_quo_next[i] = {div_qin[i][sbu_pkg::FRAC_BITS-2:0], div_take[i]};
        end
    end

    // ------------------------------------------------------------------
    // Multiply 1: hh = h * (1 - h) and p = d * h. Since t - b is -d for
    // union and d for subtraction, the blend sum is w = d*h + k*hh, negated
    // for union.
    // ------------------------------------------------------------------
    localparam int LastDiv = sbu_pkg::DIV_STEPS - 1;

    logic                                                m1_vld_reg, m1_vld_next;
    sbu_pkg::carry_t                                     m1_carry_reg, m1_carry_next;
    logic signed [sbu_pkg::VALUE_WIDTH+sbu_pkg::FRAC_BITS:0] m1_p_reg, m1_p_next;
    logic [sbu_pkg::FRAC_BITS-1:0]                       m1_hh_reg, m1_hh_next;
    logic [sbu_pkg::FRAC_BITS:0]                         m1_h_ext;
    logic [sbu_pkg::FRAC_BITS:0]                         m1_h_inv;
    logic [2*sbu_pkg::FRAC_BITS+1:0]                     m1_hprod;

    always_comb
    begin
        m1_h_ext      = {1'b0, div_quo_reg[LastDiv]};
        m1_h_inv      = {1'b1, {sbu_pkg::FRAC_BITS{1'b0}}} - m1_h_ext;
        m1_hprod      = m1_h_ext * m1_h_inv;
        m1_vld_next   = div_vld_reg[LastDiv];
        m1_carry_next = div_carry_reg[LastDiv];
        m1_hh_next    = m1_hprod[2*sbu_pkg::FRAC_BITS-1:sbu_pkg::FRAC_BITS];
        m1_p_next     = div_carry_reg[LastDiv].drv * $signed(m1_h_ext);
    end

    // Multiply 2: q = k * hh.
    logic                                                m2_vld_reg, m2_vld_next;
    sbu_pkg::carry_t                                     m2_carry_reg, m2_carry_next;
    logic signed [sbu_pkg::VALUE_WIDTH+sbu_pkg::FRAC_BITS:0] m2_p_reg, m2_p_next;
    logic [sbu_pkg::K_WIDTH+sbu_pkg::FRAC_BITS-1:0]      m2_q_reg, m2_q_next;

    always_comb
    begin
        m2_vld_next   = m1_vld_reg;
        m2_carry_next = m1_carry_reg;
        m2_p_next     = m1_p_reg;
        m2_q_next     = m1_carry_reg.radius * m1_hh_reg;
    end

    // Add stage: v = +/-(p + q), still at full fraction precision.
    logic                                                  m3_vld_reg, m3_vld_next;
    sbu_pkg::carry_t                                       m3_carry_reg, m3_carry_next;
    logic signed [sbu_pkg::VALUE_WIDTH+sbu_pkg::FRAC_BITS+1:0] m3_v_reg, m3_v_next;
    logic signed [sbu_pkg::VALUE_WIDTH+sbu_pkg::FRAC_BITS+1:0] m3_p_ext;
    logic signed [sbu_pkg::VALUE_WIDTH+sbu_pkg::FRAC_BITS+1:0] m3_q_ext;
    logic signed [sbu_pkg::VALUE_WIDTH+sbu_pkg::FRAC_BITS+1:0] m3_w;

    always_comb
    begin
        m3_p_ext      = {m2_p_reg[sbu_pkg::VALUE_WIDTH+sbu_pkg::FRAC_BITS], m2_p_reg};
        m3_q_ext      = {3'b000, m2_q_reg};
        m3_w          = m3_p_ext + m3_q_ext;
        m3_vld_next   = m2_vld_reg;
        m3_carry_next = m2_carry_reg;
        m3_v_next     = m2_carry_reg.union_op ? -m3_w : m3_w;
    end

    // ------------------------------------------------------------------
    // Output stage: floor v to an integer count of LSBs by dropping the
    // fraction bits (an arithmetic shift floors), add b, pick the preset
    // result when the band test decided it, then saturate.
    // ------------------------------------------------------------------
    logic                                   done_reg, done_next;
    logic signed [sbu_pkg::VALUE_WIDTH-1:0] blended_reg, blended_next;
    logic                                   overflow_reg, overflow_next;
    logic signed [sbu_pkg::VALUE_WIDTH+1:0] m4_shift;
    logic signed [sbu_pkg::WIDE_WIDTH-1:0]  m4_base_ext;
    logic signed [sbu_pkg::WIDE_WIDTH-1:0]  m4_shift_ext;
    logic signed [sbu_pkg::WIDE_WIDTH-1:0]  m4_sum;
    logic signed [sbu_pkg::WIDE_WIDTH-1:0]  m4_res;
    logic [sbu_pkg::WIDE_WIDTH-sbu_pkg::VALUE_WIDTH:0] m4_top;

    always_comb
    begin
        m4_shift     = m3_v_reg[sbu_pkg::VALUE_WIDTH+sbu_pkg::FRAC_BITS+1:sbu_pkg::FRAC_BITS];
        m4_base_ext  = {{(sbu_pkg::WIDE_WIDTH-sbu_pkg::VALUE_WIDTH)
                         {m3_carry_reg.base[sbu_pkg::VALUE_WIDTH-1]}}, m3_carry_reg.base};
        m4_shift_ext = {{(sbu_pkg::WIDE_WIDTH-sbu_pkg::VALUE_WIDTH-2)
                         {m4_shift[sbu_pkg::VALUE_WIDTH+1]}}, m4_shift};
        m4_sum       = m4_base_ext + m4_shift_ext;
        m4_res       = m3_carry_reg.bypass ? m3_carry_reg.preset : m4_sum;
        m4_top       = m4_res[sbu_pkg::WIDE_WIDTH-1:sbu_pkg::VALUE_WIDTH-1];

        done_next     = m3_vld_reg;
        overflow_next = !((m4_top == '0) || (m4_top == '1));
        if (!overflow_next)
        begin
            blended_next = m4_res[sbu_pkg::VALUE_WIDTH-1:0];
        end
        else if (m4_res[sbu_pkg::WIDE_WIDTH-1])
        begin
            blended_next = {1'b1, {(sbu_pkg::VALUE_WIDTH-1){1'b0}}};
        end
        else
        begin
            blended_next = {1'b0, {(sbu_pkg::VALUE_WIDTH-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------
    // Valid bits, cleared by reset.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            for (int i = 0; i < sbu_pkg::DIV_STEPS; i++)
            begin
                div_vld_reg[i] <= 1'b0;
            end
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
            for (int i = 0; i < sbu_pkg::DIV_STEPS; i++)
            begin
                div_vld_reg[i] <= div_vld_next[i];
            end
            m1_vld_reg <= m1_vld_next;
            m2_vld_reg <= m2_vld_next;
            m3_vld_reg <= m3_vld_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers move every cycle alongside their valid bits.
    always_ff @(posedge clk)
    begin
        s1_cmd_reg   <= s1_cmd_next;
        s1_t_reg     <= s1_t_next;
        s1_b_reg     <= s1_b_next;
        s1_k_reg     <= s1_k_next;
        s2_cmd_reg   <= s2_cmd_next;
        s2_t_reg     <= s2_t_next;
        s2_b_reg     <= s2_b_next;
        s2_k_reg     <= s2_k_next;
        s2_d_reg     <= s2_d_next;
        s3_carry_reg <= s3_carry_next;
        s3_num_reg   <= s3_num_next;
        for (int i = 0; i < sbu_pkg::DIV_STEPS; i++)
        begin
            div_carry_reg[i] <= div_carry_next[i];
            div_rem_reg[i]   <= div_rem_next[i];
            div_quo_reg[i]   <= div_quo_next[i];
        end
        m1_carry_reg <= m1_carry_next;
        m1_p_reg     <= m1_p_next;
        m1_hh_reg    <= m1_hh_next;
        m2_carry_reg <= m2_carry_next;
        m2_p_reg     <= m2_p_next;
        m2_q_reg     <= m2_q_next;
        m3_carry_reg <= m3_carry_next;
        m3_v_reg     <= m3_v_next;
        blended_reg  <= blended_next;
        overflow_reg <= overflow_next;
    end

    // The pipeline never stalls, so a beat is always welcome.
    assign busy     = 1'b0;
    assign done     = done_reg;
    assign blended  = blended_reg;
    assign overflow = overflow_reg;

endmodule

// ===== sv/sbu_chk.sv =====
// ----------------------------------------------------------------------------
// sbu_chk
// Port-level checks of the distance blend unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sdf_blend_unit_assert.svh"

module sbu_chk (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic [1:0]                            command,
    input logic signed [sbu_pkg::VALUE_WIDTH-1:0] dist_a,
    input logic signed [sbu_pkg::VALUE_WIDTH-1:0] dist_b,
    input logic [sbu_pkg::K_WIDTH-1:0]           blend_width,
    input logic                                  done,
    input logic signed [sbu_pkg::VALUE_WIDTH-1:0] blended,
    input logic                                  overflow
);

    // Every result beat answers a beat accepted exactly one latency earlier.
    `SBU_ASSERT_IMP(a_done_follows_beat, done, $past(start && !busy, sbu_pkg::PIPE_LATENCY), "result beat without an accepted input beat")

    // A flagged result must sit on one of the two range limits.
    `SBU_ASSERT_IMP(a_overflow_at_limit, done && overflow, (blended == 32'h7fff_ffff) || (blended == 32'h8000_0000), "overflow flagged on an unsaturated value")

    // Hard minimum returns one input, the smaller, without overflow.
    `SBU_ASSERT_IMP(a_hard_min, done && ($past(command, sbu_pkg::PIPE_LATENCY) == sbu_pkg::CMD_HARD_MIN), !overflow && (blended == (($past(dist_a, sbu_pkg::PIPE_LATENCY) <= $past(dist_b, sbu_pkg::PIPE_LATENCY)) ? $past(dist_a, sbu_pkg::PIPE_LATENCY) : $past(dist_b, sbu_pkg::PIPE_LATENCY))), "hard minimum result wrong")

    // Smooth union with zero radius collapses to the hard minimum.
    `SBU_ASSERT_IMP(a_zero_radius_union, done && $past((command == sbu_pkg::CMD_SMOOTH_UNION) && (blend_width == '0), sbu_pkg::PIPE_LATENCY), !overflow && (blended == (($past(dist_a, sbu_pkg::PIPE_LATENCY) <= $past(dist_b, sbu_pkg::PIPE_LATENCY)) ? $past(dist_a, sbu_pkg::PIPE_LATENCY) : $past(dist_b, sbu_pkg::PIPE_LATENCY))), "zero radius union differs from minimum")

endmodule

bind sdf_blend_unit sbu_chk u_sbu_chk (.*);
